### sv/ple_pkg.sv
// ple_pkg: shared types and codes for the positional list engine.
// Holds request/result payload structs, opcode and status codes.
// No dependencies.
`default_nettype none

package ple_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int OPC_W  = 3;
	localparam int POS_W  = 7;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 6;
	localparam int LEN_W  = 7;

	localparam logic [OPC_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OPC_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OPC_W-1:0] OP_READ   = 3'd2;
	localparam logic [OPC_W-1:0] OP_CHANGE = 3'd3;
	localparam logic [OPC_W-1:0] OP_LOCATE = 3'd4;
	localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd5;
	localparam logic [OPC_W-1:0] OP_DEDUP  = 3'd6;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		logic [OPC_W-1:0]         opcode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic                     status;
		logic signed [DATA_W-1:0] read_value;
		logic                     found;
		logic [IDX_W-1:0]         found_index;
		logic [LEN_W-1:0]         length;
		logic                     is_full;
		logic                     is_empty;
	} res_t;

endpackage

`default_nettype wire

### sv/ple_mem.sv
// ple_mem: entry store of the positional list engine.
// One write port, one read port with registered read data.
// Depends on ple_pkg for the data width.
`default_nettype none

module ple_mem #(
	parameter int DEPTH = ple_pkg::CAPACITY_DEF,
	parameter int AW    = 6
) (
	input  wire logic                        clk,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [ple_pkg::DATA_W-1:0]  wdata,
	output logic [ple_pkg::DATA_W-1:0]       rdata
);

	logic [ple_pkg::DATA_W-1:0] mem [DEPTH];
	logic [ple_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### sv/ple_ctrl.sv
// ple_ctrl: sequencer of the positional list engine.
// Holds the entry count, walks the entry store for shifts, searches and dedup.
// Depends on ple_pkg; drives the ports of ple_mem.
`default_nettype none

module ple_ctrl #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF,
	parameter int AW       = 6,
	parameter int CW       = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire ple_pkg::req_t              req,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output ple_pkg::res_t                   res,
	output logic                            mem_re,
	output logic [AW-1:0]                   mem_raddr,
	output logic                            mem_we,
	output logic [AW-1:0]                   mem_waddr,
	output logic [ple_pkg::DATA_W-1:0]      mem_wdata,
	input  wire logic [ple_pkg::DATA_W-1:0] mem_rdata
);

	localparam int XW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SHIFT,
		S_DRAIN,
		S_PUT,
		S_RD_ISSUE,
		S_RD_DATA,
		S_SCAN,
		S_DD_RD,
		S_DD_RDAT,
		S_DD_PUT,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [ple_pkg::OPC_W-1:0]    op_q;
	logic [XW-1:0]                pos_q;
	logic [ple_pkg::DATA_W-1:0]   val_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                i_q;
	logic [CW-1:0]                chk_q;
	logic [CW-1:0]                lim_q;
	logic [CW-1:0]                r_q;
	logic [CW-1:0]                w_q;
	logic [AW-1:0]                wa_q;
	logic                         pend_q;
	logic                         status_q;
	logic [ple_pkg::DATA_W-1:0]   rd_q;
	logic                         found_q;
	logic [CW-1:0]                fidx_q;

	logic [XW-1:0]                cnt_x;
	logic [XW-1:0]                req_pos_x;
	logic [XW-1:0]                fidx_x;
	logic [XW-1:0]                len_x;
	logic                         is_full;
	logic                         scan_more;
	logic                         scan_hit;
	logic                         is_ins;
	logic                         is_loc;

	assign cnt_x     = XW'(cnt_q);
	assign req_pos_x = XW'(req.position);
	assign fidx_x    = XW'(fidx_q);
	assign len_x     = XW'(cnt_q);
	assign is_full   = (cnt_q == CW'(CAPACITY));
	assign scan_more = (i_q < lim_q);
	assign scan_hit  = pend_q && (mem_rdata == val_q);
	assign is_ins    = (op_q == ple_pkg::OP_INSERT);
	assign is_loc    = (op_q == ple_pkg::OP_LOCATE);

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = i_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = wa_q;
		mem_wdata = mem_rdata;
		case (state_q)
			S_SHIFT: begin
				mem_re = 1'b1;
				mem_we = pend_q;
			end
			S_DRAIN: begin
				mem_we = 1'b1;
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = val_q;
			end
			S_RD_ISSUE: begin
				mem_re    = 1'b1;
				mem_raddr = pos_q[AW-1:0];
			end
			S_SCAN: begin
				mem_re = scan_more;
			end
			S_DD_RD: begin
				mem_re    = (r_q < cnt_q);
				mem_raddr = r_q[AW-1:0];
			end
			S_DD_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = w_q[AW-1:0];
				mem_wdata = val_q;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= '0;
			pos_q    <= '0;
			val_q    <= '0;
			cnt_q    <= '0;
			i_q      <= '0;
			chk_q    <= '0;
			lim_q    <= '0;
			r_q      <= '0;
			w_q      <= '0;
			wa_q     <= '0;
			pend_q   <= 1'b0;
			status_q <= ple_pkg::STATUS_OK;
			rd_q     <= '0;
			found_q  <= 1'b0;
			fidx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q     <= req.opcode;
						pos_q    <= req_pos_x;
						val_q    <= req.item_value;
						status_q <= ple_pkg::STATUS_OK;
						rd_q     <= '0;
						found_q  <= 1'b0;
						fidx_q   <= '0;
						pend_q   <= 1'b0;
						state_q  <= S_DONE;
						case (req.opcode)
							ple_pkg::OP_INSERT: begin
								if (is_full || req_pos_x > cnt_x) begin
									status_q <= ple_pkg::STATUS_FAIL;
								end else if (req_pos_x == cnt_x) begin
									state_q <= S_PUT;
								end else begin
									i_q     <= cnt_q - CW'(1);
									state_q <= S_SHIFT;
								end
							end
							ple_pkg::OP_DELETE: begin
								if (req_pos_x >= cnt_x) begin
									status_q <= ple_pkg::STATUS_FAIL;
								end else if (req_pos_x == cnt_x - XW'(1)) begin
									cnt_q <= cnt_q - CW'(1);
								end else begin
									i_q     <= CW'(req_pos_x + XW'(1));
									state_q <= S_SHIFT;
								end
							end
							ple_pkg::OP_READ: begin
								if (req_pos_x >= cnt_x) begin
									status_q <= ple_pkg::STATUS_FAIL;
								end else begin
									state_q <= S_RD_ISSUE;
								end
							end
							ple_pkg::OP_CHANGE: begin
								if (req_pos_x >= cnt_x) begin
									status_q <= ple_pkg::STATUS_FAIL;
								end else begin
									state_q <= S_PUT;
								end
							end
							ple_pkg::OP_LOCATE: begin
								i_q     <= '0;
								lim_q   <= cnt_q;
								state_q <= S_SCAN;
							end
							ple_pkg::OP_CLEAR: begin
								cnt_q <= '0;
							end
							ple_pkg::OP_DEDUP: begin
								r_q     <= '0;
								w_q     <= '0;
								state_q <= S_DD_RD;
							end
							default: begin
								status_q <= ple_pkg::STATUS_FAIL;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// read one entry a cycle, write it one place over in the next
					pend_q <= 1'b1;
					if (is_ins) begin
						wa_q <= AW'(i_q + CW'(1));
						if (XW'(i_q) == pos_q) begin
							state_q <= S_DRAIN;
						end else begin
							i_q <= i_q - CW'(1);
						end
					end else begin
						wa_q <= AW'(i_q - CW'(1));
						if (i_q == cnt_q - CW'(1)) begin
							state_q <= S_DRAIN;
						end else begin
							i_q <= i_q + CW'(1);
						end
					end
				end
				S_DRAIN: begin
					if (is_ins) begin
						state_q <= S_PUT;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_PUT: begin
					if (is_ins) begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					rd_q    <= mem_rdata;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					// data for chk_q arrives while the next read is issued
					pend_q <= scan_more;
					chk_q  <= i_q;
					if (scan_more) begin
						i_q <= i_q + CW'(1);
					end
					if (scan_hit) begin
						if (is_loc) begin
							found_q <= 1'b1;
							fidx_q  <= chk_q;
							state_q <= S_DONE;
						end else begin
							r_q     <= r_q + CW'(1);
							state_q <= S_DD_RD;
						end
					end else if (!scan_more) begin
						state_q <= is_loc ? S_DONE : S_DD_PUT;
					end
				end
				S_DD_RD: begin
					if (r_q >= cnt_q) begin
						cnt_q   <= w_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DD_RDAT;
					end
				end
				S_DD_RDAT: begin
					// compare the candidate against the kept prefix
					val_q   <= mem_rdata;
					i_q     <= '0;
					lim_q   <= w_q;
					pend_q  <= 1'b0;
					state_q <= S_SCAN;
				end
				S_DD_PUT: begin
					w_q     <= w_q + CW'(1);
					r_q     <= r_q + CW'(1);
					state_q <= S_DD_RD;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready       = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.read_value  = signed'(rd_q);
	assign res.found       = found_q;
	assign res.found_index = fidx_x[ple_pkg::IDX_W-1:0];
	assign res.length      = len_x[ple_pkg::LEN_W-1:0];
	assign res.is_full     = is_full;
	assign res.is_empty    = (cnt_q == '0);

endmodule

`default_nettype wire

### sv/positional_list_engine_top.sv
// positional_list_engine_top: ordered list of signed 32-bit values.
// Instantiates ple_ctrl and ple_mem, holds the result output register.
// Depends on ple_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   request | req_valid/req_ready  | ple_pkg::req_t  (opcode, position, value)
//   result  | res_valid/res_ready  | ple_pkg::res_t  (status, data, count flags)
//
// One request at a time; the store has one read and one write port.
// Insert and delete shift the entries behind the position one place, except
// when appending or deleting the last entry; read and change touch one entry,
// locate scans up to count entries, clear resets the count only; dedup scans
// the kept prefix for each entry through the single read port.
// Reset clears the count and control state; store contents stay undefined until written.
// A finished result waits in the output register while the next request is taken.
`default_nettype none

module positional_list_engine_top #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire ple_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_ready,
	output ple_pkg::res_t      res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic                       core_res_valid;
	logic                       core_res_ready;
	ple_pkg::res_t              core_res;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [ple_pkg::DATA_W-1:0] mem_wdata;
	logic [ple_pkg::DATA_W-1:0] mem_rdata;
	logic                       out_valid_q;
	ple_pkg::res_t              out_q;

	ple_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (core_res_valid),
		.res_ready (core_res_ready),
		.res       (core_res),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	ple_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// take a new result when the register is empty or being drained
	assign core_res_ready = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_valid && core_res_ready) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid && core_res_ready) begin
			out_q <= core_res;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

`default_nettype wire
